// ===== hdl/idlp_pkg.sv =====
// ----------------------------------------------------------------------------
// idlp_pkg
// Types and constants shared by the id list packer modules.
// ----------------------------------------------------------------------------
package idlp_pkg;

  localparam int CNT_W = 4;   // id count field, holds up to fifteen ids
  localparam int ID_W  = 32;

  localparam logic [ID_W-1:0] LIMIT_8  = 32'h0000_00ff;
  localparam logic [ID_W-1:0] LIMIT_16 = 32'h0000_ffff;

  typedef enum logic [1:0] {
    WC_8  = 2'd0,
    WC_16 = 2'd1,
    WC_32 = 2'd2
  } width_code_t;

  typedef struct packed {
    logic [7:0]      type_code;
    logic [ID_W-1:0] id_value;
    logic            list_empty;
    logic            is_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
    logic       overflow;
  } out_req_t;

  // list state handed from the collector to the emitter
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  max_id;
    logic             dropped;
    logic [7:0]       type_code;
  } list_stat_t;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_TYPE,
    ES_CODE,
    ES_FETCH,
    ES_BYTE
  } emit_state_t;

  function automatic width_code_t width_code_f(input logic [ID_W-1:0] max_id);
    width_code_t code;
    if (max_id <= LIMIT_8) begin
      code = WC_8;
    end else if (max_id <= LIMIT_16) begin
      code = WC_16;
    end else begin
      code = WC_32;
    end
    return code;
  endfunction

  // index of the final byte of one id at a given width
  function automatic logic [1:0] last_bsel_f(input width_code_t code);
    logic [1:0] sel;
    unique case (code)
      WC_8:    sel = 2'd0;
      WC_16:   sel = 2'd1;
      WC_32:   sel = 2'd3;
      default: sel = 2'd3;
    endcase
    return sel;
  endfunction

endpackage

// ===== hdl/idlp_ram.sv =====
// ----------------------------------------------------------------------------
// idlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idlp_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 15,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/idlp_collect.sv =====
// ----------------------------------------------------------------------------
// idlp_collect
// Input side: stores ids into the RAM, tracks count, maximum and drop flag.
// ----------------------------------------------------------------------------
module idlp_collect
  import idlp_pkg::*;
#(
  parameter int MAX_IDS = 15,
  parameter int ADDR_W  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_data,
  input  logic              done,
  output logic              start,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [ID_W-1:0]   wr_data,
  output list_stat_t        stat
);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [ID_W-1:0]  max_id;
  logic             dropped;
  logic [7:0]       type_code;
  logic             accept;
  logic             has_room;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign has_room = count < CNT_W'(MAX_IDS);
  assign start    = accept && in_data.is_last;

  assign wr_en   = accept && !in_data.list_empty && has_room;
  assign wr_addr = count[ADDR_W-1:0];
  assign wr_data = in_data.id_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      count   <= '0;
      max_id  <= '0;
      dropped <= 1'b0;
    end else if (done) begin
      busy    <= 1'b0;
      count   <= '0;
      max_id  <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (!in_data.list_empty) begin
        if (has_room) begin
          count <= count + CNT_W'(1);
          if (in_data.id_value > max_id) begin
            max_id <= in_data.id_value;
          end
        end else begin
          dropped <= 1'b1;
        end
      end
      if (in_data.is_last) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      type_code <= in_data.type_code;
    end
  end

  assign stat.count     = count;
  assign stat.max_id    = max_id;
  assign stat.dropped   = dropped;
  assign stat.type_code = type_code;

endmodule

// ===== hdl/idlp_emit.sv =====
// ----------------------------------------------------------------------------
// idlp_emit
// Output side: header bytes, then each stored id read back and sliced.
// ----------------------------------------------------------------------------
module idlp_emit
  import idlp_pkg::*;
#(
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  list_stat_t        stat,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [ID_W-1:0]   rd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_req_t          out_data,
  output logic              done,
  output logic              busy
);

  emit_state_t      state, state_next;
  width_code_t      code, code_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [1:0]       bsel, bsel_next;
  logic             slot_free;
  logic             load;
  out_req_t         load_data;
  logic [7:0]       sel_byte;
  logic             last_id;
  logic             last_b;

  assign slot_free = !out_valid || !out_stall;
  assign last_id   = (idx + CNT_W'(1)) == stat.count;
  assign last_b    = bsel == last_bsel_f(code);
  assign rd_addr   = idx[ADDR_W-1:0];
  assign busy      = state != ES_IDLE;

  always_comb begin
    unique case (bsel)
      2'd0: sel_byte = rd_data[7:0];
      2'd1: sel_byte = rd_data[15:8];
      2'd2: sel_byte = rd_data[23:16];
      2'd3: sel_byte = rd_data[31:24];
      default: sel_byte = rd_data[7:0];
    endcase
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    idx_next   = idx;
    bsel_next  = bsel;
    load       = 1'b0;
    done       = 1'b0;
    rd_en      = 1'b0;
    load_data.byte_value = stat.type_code;
    load_data.last_byte  = 1'b0;
    load_data.overflow   = stat.dropped;
    unique case (state)
      ES_IDLE: begin
        if (start) begin
          state_next = ES_TYPE;
        end
      end
      ES_TYPE: begin
        code_next = width_code_f(stat.max_id);
        if (slot_free) begin
          load       = 1'b1;
          state_next = ES_CODE;
        end
      end
      ES_CODE: begin
        load_data.byte_value = {6'd0, code};
        load_data.last_byte  = stat.count == '0;
        if (slot_free) begin
          load     = 1'b1;
          idx_next = '0;
          if (stat.count == '0) begin
            done       = 1'b1;
            state_next = ES_IDLE;
          end else begin
            state_next = ES_FETCH;
          end
        end
      end
      ES_FETCH: begin
        rd_en      = 1'b1;
        bsel_next  = '0;
        state_next = ES_BYTE;
      end
      ES_BYTE: begin
        load_data.byte_value = sel_byte;
        load_data.last_byte  = last_id && last_b;
        if (slot_free) begin
          load = 1'b1;
          if (!last_b) begin
            bsel_next = bsel + 2'd1;
          end else if (last_id) begin
            done       = 1'b1;
            state_next = ES_IDLE;
          end else begin
            idx_next   = idx + CNT_W'(1);
            state_next = ES_FETCH;
          end
        end
      end
      default: state_next = ES_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ES_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    code <= code_next;
    idx  <= idx_next;
    bsel <= bsel_next;
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== hdl/id_list_adaptive_width_packer.sv =====
// ----------------------------------------------------------------------------
// id_list_adaptive_width_packer
// Collects a list of 32-bit ids and emits it as a packed byte record with an
// adaptive id width chosen from the list maximum.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload   | one request carries
//  --------+----------------------+-----------+------------------------------
//  in      | in_valid / in_stall  | in_data   | one id, type byte, markers
//  out     | out_valid / out_stall| out_data  | one record byte
//
//  Input requests are taken one per cycle while a list is collected. From the
//  last request on, the record carries the type byte and the width code
//  byte, then per stored id a RAM read and 1, 2 or 4 bytes, paced by the RAM
//  read port and the single output register and held when the output stalls.
//  in_stall is high from the last request until the final record byte has
//  entered the output register.
//  Reset (rst, synchronous) clears count, maximum, drop flag and both valid
//  paths; the id RAM is not cleared, only written entries are read back.
//
module id_list_adaptive_width_packer
  import idlp_pkg::*;
#(
  parameter int MAX_IDS = 15   // 1 .. 15
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  localparam int ADDR_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

  // collector -> RAM write port
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ID_W-1:0]   wr_data;
  // emitter -> RAM read port
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ID_W-1:0]   rd_data;
  // hand-over between collector and emitter
  list_stat_t        stat;
  logic              start;      // last request accepted
  logic              done;       // final byte loaded, list state cleared
  logic              emit_busy;

  idlp_collect #(
    .MAX_IDS (MAX_IDS),
    .ADDR_W  (ADDR_W)
  ) u_collect (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .done     (done),
    .start    (start),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .stat     (stat)
  );

  // id store: one entry per kept id
  idlp_ram #(
    .WIDTH  (ID_W),
    .DEPTH  (MAX_IDS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // reads and writes never overlap: writes only while the emitter is idle
  idlp_emit #(
    .ADDR_W (ADDR_W)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .stat      (stat),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .done      (done),
    .busy      (emit_busy)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_input_while_emitting: assert property (
    @(posedge clk) disable iff (rst) emit_busy |-> in_stall
  ) else $error("input accepted while a record is being emitted");

  a_start_when_idle: assert property (
    @(posedge clk) disable iff (rst) start |-> !emit_busy
  ) else $error("new record started while emitter busy");

  a_count_in_range: assert property (
    @(posedge clk) disable iff (rst) stat.count <= CNT_W'(MAX_IDS)
  ) else $error("id count beyond capacity");

  a_done_ends_record: assert property (
    @(posedge clk) disable iff (rst) done |=> (out_valid && out_data.last_byte)
  ) else $error("record closed without a final byte");

endmodule

// ===== test/id_list_adaptive_width_packer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id_list_adaptive_width_packer_tb
// Self-checking bench for the id list packer. A fixed table of requests comes
// first: empty lists, the width thresholds, the widest id and a list that
// overruns capacity. Random lists follow, mostly well formed. Every output
// byte is checked against a behavioural copy of the packer. The sender and
// receiver idle at random in several phases.
// ----------------------------------------------------------------------------
module id_list_adaptive_width_packer_tb;
  import idlp_pkg::*;

  localparam int MAX_IDS     = 15;
  localparam int RAND_ITEMS  = 270;   // counted ids and empty closing requests; strays and the table come on top
  localparam int STALL_LIMIT = 2000;  // cycles with no request moving
  localparam int TAIL_CYCLES = 16;    // settle time after the last byte

  // one row of stimulus; typed_n > 0 means the record is spelt out here
  typedef struct {
    in_req_t    req;
    int         typed_n;
    logic [7:0] typed [6];
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_data;

  // packer state as the bench sees it
  logic [ID_W-1:0] ids_held [MAX_IDS];
  int              held_cnt;
  logic [ID_W-1:0] held_max;
  logic            held_drop;

  out_req_t  record_bytes [$];   // bytes of the record just predicted
  out_req_t  expected_bytes [$]; // bytes still owed by the packer
  stim_row_t dir_rows [$];

  int n_errors      = 0;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int quiet_cycles  = 0;

  id_list_adaptive_width_packer #(
    .MAX_IDS(MAX_IDS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (n_errors < 40) begin
      $display("%0t mismatch: %s", $time, what);
    end
    n_errors++;
  endtask

  function automatic stim_row_t mk_row(input logic [7:0] t, input logic [ID_W-1:0] id,
                                       input logic e, input logic l, input int n = 0,
                                       input logic [47:0] tb = '0);
    stim_row_t row;
    row.req.type_code  = t;
    row.req.id_value   = id;
    row.req.list_empty = e;
    row.req.is_last    = l;
    row.typed_n        = n;
    for (int k = 0; k < 6; k++) begin
      row.typed[k] = tb[47-8*k -: 8];
    end
    return row;
  endfunction

  // Mirror of the packer: store the id (or note a drop), and on the last
  // request build the whole record into record_bytes.
  function automatic void predict_record(input in_req_t r);
    width_code_t wc;
    int          nbytes;
    int          total;
    int          k;
    out_req_t    ob;
    record_bytes.delete();
    if (!r.list_empty) begin
      if (held_cnt < MAX_IDS) begin
        ids_held[held_cnt] = r.id_value;
        held_cnt++;
        if (r.id_value > held_max) held_max = r.id_value;
      end else begin
        held_drop = 1'b1;  // over capacity: max is left alone
      end
    end
    if (!r.is_last) return;
    if (held_cnt == 0 || held_max <= LIMIT_8) begin
      wc = WC_8;
      nbytes = 1;
    end else if (held_max <= LIMIT_16) begin
      wc = WC_16;
      nbytes = 2;
    end else begin
      wc = WC_32;
      nbytes = 4;
    end
    total = 2 + held_cnt * nbytes;
    ob.overflow   = held_drop;
    ob.byte_value = r.type_code;
    ob.last_byte  = 1'b0;
    record_bytes = {record_bytes, ob};
    ob.byte_value = {6'd0, wc};
    ob.last_byte  = (total == 2);
    record_bytes = {record_bytes, ob};
    k = 2;
    for (int i = 0; i < held_cnt; i++) begin
      for (int b = 0; b < nbytes; b++) begin
        k++;
        ob.byte_value = ids_held[i][8*b +: 8];  // little-endian, truncated
        ob.last_byte  = (k == total);
        record_bytes = {record_bytes, ob};
      end
    end
    held_cnt  = 0;
    held_max  = '0;
    held_drop = 1'b0;
  endfunction

  // Offer one request, wait for it to be taken, then book its record.
  // in_valid gets a single assignment per edge, so back-to-back requests
  // keep valid high throughout.
  task automatic push_req(input stim_row_t row);
    out_req_t ob;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= row.req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_record(row.req);
    if (row.typed_n > 0) begin
      for (int k = 0; k < row.typed_n; k++) begin
        ob.byte_value = row.typed[k];
        ob.last_byte  = (k == row.typed_n - 1);
        ob.overflow   = 1'b0;
        expected_bytes = {expected_bytes, ob};
      end
    end else begin
      expected_bytes = {expected_bytes, record_bytes};
    end
  endtask

  // ids drawn per list width class, with the threshold values now and then
  function automatic logic [ID_W-1:0] pick_id(input int cls);
    logic [ID_W-1:0] v;
    logic            edge_pick;
    edge_pick = ($urandom_range(0, 9) == 0);
    unique case (cls)
      0:       v = edge_pick ? ($urandom_range(0, 1) ? LIMIT_8 : '0) : $urandom_range(0, 255);
      1:       v = edge_pick ? ($urandom_range(0, 1) ? LIMIT_16 : LIMIT_8 + 1)
                             : $urandom_range(0, 65535);
      default: v = edge_pick ? ($urandom_range(0, 1) ? '1 : LIMIT_16 + 1) : $urandom;
    endcase
    return v;
  endfunction

  // receiver: random stall, check every byte taken
  always @(posedge clk) begin
    out_req_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_data.byte_value));
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.byte_value !== want.byte_value)
            report_mismatch($sformatf("byte_value %02h, want %02h",
                                      out_data.byte_value, want.byte_value));
          if (out_data.last_byte !== want.last_byte)
            report_mismatch($sformatf("last_byte %b, want %b",
                                      out_data.last_byte, want.last_byte));
          if (out_data.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, want %b",
                                      out_data.overflow, want.overflow));
        end
      end
    end
  end

  // watchdog: too long with no request moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[id_list_adaptive_width_packer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int items;
    int list_no;
    int len;
    int cls;
    int sel;
    bit end_empty;

    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    held_cnt  = 0;
    held_max  = '0;
    held_drop = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    // empty list straight after reset: header only, narrow code
    dir_rows = {dir_rows, mk_row(8'hA5, 32'hFFFF_0000, 1'b1, 1'b1, 2,
                                 {8'hA5, 6'd0, WC_8, 32'h0})};
    // smallest id, then the top of the 8-bit range
    dir_rows = {dir_rows, mk_row(8'h00, 32'h0, 1'b0, 1'b0)};
    dir_rows = {dir_rows, mk_row(8'h00, 32'h0000_00FF, 1'b0, 1'b1, 4,
                                 {8'h00, 6'd0, WC_8, 8'h00, 8'hFF, 16'h0})};
    // just past 8 bits
    dir_rows = {dir_rows, mk_row(8'h5A, 32'h0000_0100, 1'b0, 1'b1, 4,
                                 {8'h5A, 6'd0, WC_16, 8'h00, 8'h01, 16'h0})};
    // widest id, all ones type byte
    dir_rows = {dir_rows, mk_row(8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 6,
                                 {8'hFF, 6'd0, WC_32, 32'hFFFF_FFFF})};
    // empty request mid-list, then an empty last request closing a stored id
    dir_rows = {dir_rows, mk_row(8'h11, 32'hFFFF_FFFF, 1'b1, 1'b0)};
    dir_rows = {dir_rows, mk_row(8'h22, 32'h1234_5678, 1'b0, 1'b0)};
    dir_rows = {dir_rows, mk_row(8'hC3, 32'h0, 1'b1, 1'b1)};
    // full list, then one more id that must be dropped without touching max
    for (int i = 0; i < MAX_IDS; i++) begin
      dir_rows = {dir_rows, mk_row(8'h96, (i == 0) ? LIMIT_16 : ID_W'(i), 1'b0, 1'b0)};
    end
    dir_rows = {dir_rows, mk_row(8'h96, 32'hFFFF_FFFF, 1'b0, 1'b1)};
    // drop flag must be gone on the next list
    dir_rows = {dir_rows, mk_row(8'h01, 32'h0000_0080, 1'b0, 1'b1, 3,
                                 {8'h01, 6'd0, WC_8, 8'h80, 24'h0})};
    foreach (dir_rows[j]) push_req(dir_rows[j]);

    // random lists, idle phases rotating every few lists
    items   = 0;
    list_no = 0;
    while (items < RAND_ITEMS) begin
      unique case ((list_no / 6) % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 45; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 45; end
        default: begin snd_idle_pct = 8; rcv_stall_pct = 8; end
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 10)      len = 0;
      else if (sel < 80) len = $urandom_range(1, MAX_IDS - 1);
      else if (sel < 90) len = MAX_IDS;
      else               len = $urandom_range(MAX_IDS + 1, MAX_IDS + 5);
      cls = $urandom_range(0, 2);
      end_empty = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < len; n++) begin
        // stray empty request: carries nothing, not counted
        if ($urandom_range(0, 99) < 8)
          push_req(mk_row(8'($urandom), $urandom, 1'b1, 1'b0));
        push_req(mk_row(8'($urandom), pick_id(cls), 1'b0, !end_empty && (n == len - 1)));
        items++;
      end
      if (end_empty) begin
        push_req(mk_row(8'($urandom), $urandom, 1'b1, 1'b1));
        items++;
      end
      list_no++;
    end
    in_valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("[id_list_adaptive_width_packer] OK");
    end else begin
      $display("[id_list_adaptive_width_packer] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/idlp_pkg.sv
hdl/idlp_ram.sv
hdl/idlp_collect.sv
hdl/idlp_emit.sv
hdl/id_list_adaptive_width_packer.sv
test/id_list_adaptive_width_packer_tb.sv
